>>> rtl/core/rcid_pkg.sv
// Shared types and constants of the run/copy image decompressor core.
`timescale 1ns / 1ps

package rcid_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int HistDepth = 2 * MaxWidth;
	localparam int HistAw    = $clog2(HistDepth);
	localparam int DimW      = 11;
	localparam int DistW     = DimW + 1;
	localparam int IdxW      = $clog2(MaxWidth * MaxHeight);
	localparam int TotW      = IdxW + 1;
	localparam int RunW      = 10;
	localparam int QDepth    = 4;
	localparam int QAw       = $clog2(QDepth);

	localparam logic [7:0] CMD_UP1     = 8'hFF;
	localparam logic [7:0] CMD_UP2     = 8'hFE;
	localparam logic [7:0] CMD_FILL    = 8'hFD;
	localparam logic [7:0] CMD_PAIR    = 8'hFC;
	localparam logic [7:0] CMD_UPLEFT  = 8'hFB;
	localparam logic [7:0] CMD_UPRIGHT = 8'hFA;
	localparam logic [7:0] CMD_PACK    = 8'hF9;
	localparam logic [7:0] CMD_ESC     = 8'hF8;

	localparam logic [1:0] KIND_ZERO   = 2'd0;
	localparam logic [1:0] KIND_DIRECT = 2'd1;
	localparam logic [1:0] KIND_HIST   = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_DEPTH  = 2'd2;

	typedef struct packed {
		logic [DimW-1:0] width;
		logic [TotW-1:0] total;
		logic            m16;
	} geom_t;

	typedef struct packed {
		logic              pv;
		logic [1:0]        kind;
		logic [15:0]       value;
		logic [HistAw-1:0] raddr;
		logic [HistAw-1:0] waddr;
		logic              last;
		logic              pend;
		logic              rej;
	} req_t;

	typedef struct packed {
		logic        pv;
		logic [15:0] px;
		logic        last;
		logic        pend;
		logic        rej;
	} res_t;

endpackage

>>> rtl/core/rcid_front.sv
// Command decoder: parses bytes and ticks into pixel requests.
`timescale 1ns / 1ps

module rcid_front import rcid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       action,
	input  logic [7:0] data_byte,
	input  geom_t      geom,
	output req_t       req
);

	localparam logic [3:0] PH_CMD   = 4'd0;
	localparam logic [3:0] PH_COUNT = 4'd1;
	localparam logic [3:0] PH_C1LO  = 4'd2;
	localparam logic [3:0] PH_C1HI  = 4'd3;
	localparam logic [3:0] PH_C2LO  = 4'd4;
	localparam logic [3:0] PH_C2HI  = 4'd5;
	localparam logic [3:0] PH_LITLO = 4'd6;
	localparam logic [3:0] PH_LITHI = 4'd7;
	localparam logic [3:0] PH_PHEAD = 4'd8;
	localparam logic [3:0] PH_PDATA = 4'd9;
	localparam logic [3:0] PH_RUN   = 4'd10;

	logic [3:0]      ph_q, ph_n;
	logic [7:0]      cmd_q, cmd_n;
	logic [RunW-1:0] rr_q, rr_n, rr_dec;
	logic [15:0]     c1_q, c1_n, c2_q, c2_n;
	logic            tg_q, tg_n;
	logic [IdxW-1:0] pidx_q, pidx_n;
	logic [TotW-1:0] pidx_inc;
	logic            emit, do_start, last, rej, hist_ok;
	logic [1:0]      ekind;
	logic [15:0]     ev;
	logic [DistW-1:0] back_d;
	logic [7:0]      n8;

	function automatic logic [RunW-1:0] start_len(input logic [7:0] cmd,
		input logic [7:0] n, input logic m16);
		logic [RunW-1:0] nn;
		nn = {{(RunW-8){1'b0}}, n};
		if (cmd == CMD_FILL)
			return nn + (m16 ? RunW'(3) : RunW'(4));
		else if (cmd == CMD_PAIR)
			return RunW'((nn + (m16 ? RunW'(2) : RunW'(3))) << 1);
		else
			return nn + (m16 ? RunW'(2) : RunW'(3));
	endfunction

	always_comb begin
		ph_n = ph_q; cmd_n = cmd_q; rr_n = rr_q; c1_n = c1_q; c2_n = c2_q;
		tg_n = tg_q; pidx_n = pidx_q;
		emit = 1'b0; do_start = 1'b0; last = 1'b0; rej = 1'b0;
		ekind = KIND_DIRECT; ev = 16'h0000; back_d = '0;
		n8 = (ph_q == PH_COUNT) ? data_byte : rr_q[7:0];
		rr_dec = rr_q - ((rr_q != '0) ? RunW'(1) : RunW'(0));
		pidx_inc = {1'b0, pidx_q} + TotW'(1);
		if (action) begin
			if (ph_q == PH_RUN) begin
				tg_n = ~tg_q;
				rr_n = rr_dec;
				if (rr_dec == '0) ph_n = PH_CMD;
				emit = 1'b1;
				if (cmd_q == CMD_UP1) begin
					ekind = KIND_HIST; back_d = {1'b0, geom.width};
				end else if (cmd_q == CMD_UP2) begin
					ekind = KIND_HIST; back_d = {geom.width, 1'b0};
				end else if (cmd_q == CMD_PAIR) begin
					ev = tg_q ? c2_q : c1_q;
				end else begin
					ev = c1_q;
				end
			end
		end else begin
			unique case (ph_q)
				PH_RUN: rej = 1'b1;
				PH_COUNT: begin
					rr_n = {{(RunW-8){1'b0}}, data_byte};
					if (cmd_q == CMD_FILL || cmd_q == CMD_PAIR) ph_n = PH_C1LO;
					else if (cmd_q == CMD_PACK) ph_n = PH_PHEAD;
					else do_start = 1'b1;
				end
				PH_C1LO: begin
					c1_n = {8'h00, data_byte};
					if (geom.m16) ph_n = PH_C1HI;
					else if (cmd_q == CMD_PAIR) ph_n = PH_C2LO;
					else do_start = 1'b1;
				end
				PH_C1HI: begin
					c1_n = {data_byte, c1_q[7:0]};
					if (cmd_q == CMD_PAIR) ph_n = PH_C2LO;
					else do_start = 1'b1;
				end
				PH_C2LO: begin
					c2_n = {8'h00, data_byte};
					if (geom.m16) ph_n = PH_C2HI;
					else do_start = 1'b1;
				end
				PH_C2HI: begin
					c2_n = {data_byte, c2_q[7:0]};
					do_start = 1'b1;
				end
				PH_LITLO: begin
					c1_n = {8'h00, data_byte};
					if (geom.m16) ph_n = PH_LITHI;
					else begin
						ph_n = PH_CMD; emit = 1'b1; ev = {8'h00, data_byte};
					end
				end
				PH_LITHI: begin
					ph_n = PH_CMD; emit = 1'b1; ev = {data_byte, c1_q[7:0]};
				end
				PH_PHEAD: begin
					c1_n = {data_byte[7:5], 2'b00, data_byte[4:3], 4'b0000,
						data_byte[2:0], 2'b00};
					rr_n = {{(RunW-9){1'b0}}, {1'b0, rr_q[7:0]} + 9'd1};
					ph_n = PH_PDATA;
				end
				PH_PDATA: begin
					ev = c1_q | {3'b000, data_byte[7:6], 2'b00, data_byte[5:2], 3'b000,
						data_byte[1:0]};
					rr_n = rr_dec;
					if (rr_dec == '0) ph_n = PH_CMD;
					emit = 1'b1;
				end
				default: begin
					ph_n = PH_CMD;
					cmd_n = data_byte;
					priority if (data_byte == CMD_UP1 || data_byte == CMD_UP2 ||
						data_byte == CMD_FILL || data_byte == CMD_PAIR) begin
						ph_n = PH_COUNT;
					end else if (data_byte == CMD_ESC) begin
						ph_n = PH_LITLO;
					end else if (geom.m16 && data_byte == CMD_UPLEFT) begin
						emit = 1'b1; ekind = KIND_HIST;
						back_d = {1'b0, geom.width} + DistW'(1);
					end else if (geom.m16 && data_byte == CMD_UPRIGHT) begin
						emit = 1'b1; ekind = KIND_HIST;
						back_d = {1'b0, geom.width} - DistW'(1);
					end else if (geom.m16 && data_byte == CMD_PACK) begin
						ph_n = PH_COUNT;
					end else if (geom.m16) begin
						c1_n = {8'h00, data_byte}; ph_n = PH_LITHI;
					end else begin
						emit = 1'b1; ev = {8'h00, data_byte};
					end
				end
			endcase
		end
		if (do_start) begin
			rr_n = start_len(cmd_q, n8, geom.m16);
			tg_n = 1'b0;
			ph_n = PH_RUN;
		end
		hist_ok = (back_d != '0) && ({{(IdxW-DistW){1'b0}}, back_d} <= pidx_q);
		if (ekind == KIND_HIST && !hist_ok) ekind = KIND_ZERO;
		if (emit) begin
			if (pidx_inc >= geom.total) begin
				last = 1'b1; pidx_n = '0; ph_n = PH_CMD; rr_n = '0; tg_n = 1'b0;
			end else begin
				pidx_n = pidx_inc[IdxW-1:0];
			end
		end
		req.pv    = emit;
		req.kind  = emit ? ekind : KIND_ZERO;
		req.value = ev;
		req.raddr = pidx_q[HistAw-1:0] - back_d[HistAw-1:0];
		req.waddr = pidx_q[HistAw-1:0];
		req.last  = last;
		req.pend  = (ph_n == PH_RUN);
		req.rej   = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_CMD; cmd_q <= '0; rr_q <= '0; c1_q <= '0; c2_q <= '0;
			tg_q <= 1'b0; pidx_q <= '0;
		end else if (take) begin
			ph_q <= ph_n; cmd_q <= cmd_n; rr_q <= rr_n; c1_q <= c1_n; c2_q <= c2_n;
			tg_q <= tg_n; pidx_q <= pidx_n;
		end
	end

endmodule

>>> rtl/core/rcid_back.sv
// Pixel engine: history store read/write with forwarding, and result queue.
`timescale 1ns / 1ps

module rcid_back import rcid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mid_valid,
	input  req_t        mid_req,
	output logic        mid_pop,
	output logic        empty,
	input  logic        pop,
	output res_t        res
);

	logic [15:0]  hist_mem [HistDepth];
	logic         en;
	logic         s1_v, s2_v;
	req_t         s1_req, s2_req;
	logic [15:0]  rd_s2, fwd_val_s2, px_s2;
	logic         fwd_s2;
	res_t         oq_q [QDepth];
	logic [QAw-1:0] wp_q, rp_q;
	logic [QAw:0]   cnt_q;
	logic         o_push, o_pop;

	assign en      = (cnt_q != (QAw+1)'(QDepth));
	assign mid_pop = en && mid_valid;
	assign o_push  = en && s2_v;
	assign o_pop   = pop && !empty;
	assign empty   = (cnt_q == '0);
	assign res     = oq_q[rp_q];

	always_comb begin
		unique case (s2_req.kind)
			KIND_DIRECT: px_s2 = s2_req.value;
			KIND_HIST:   px_s2 = fwd_s2 ? fwd_val_s2 : rd_s2;
			default:     px_s2 = 16'h0000;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s2 <= hist_mem[s1_req.raddr];
			fwd_val_s2 <= px_s2;
			s2_req <= s1_req;
			s1_req <= mid_req;
			if (s2_v && s2_req.pv) hist_mem[s2_req.waddr] <= px_s2;
		end
		if (o_push) oq_q[wp_q] <= '{pv: s2_req.pv, px: px_s2, last: s2_req.last,
			pend: s2_req.pend, rej: s2_req.rej};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0; s2_v <= 1'b0; fwd_s2 <= 1'b0;
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (en) begin
				s1_v <= mid_valid;
				s2_v <= s1_v;
				fwd_s2 <= s2_v && s2_req.pv && (s2_req.waddr == s1_req.raddr);
			end
			if (o_push) wp_q <= wp_q + QAw'(1);
			if (o_pop) rp_q <= rp_q + QAw'(1);
			cnt_q <= cnt_q + (QAw+1)'(o_push) - (QAw+1)'(o_pop);
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAw+1)'(QDepth)) else $error("result queue overflow");
	a_no_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v && !s2_req.pv) |-> (px_s2 == 16'h0000)) else $error("stray pixel value");
	a_last_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v && s2_req.last) |-> s2_req.pv) else $error("last without pixel");
	a_last_not_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v && s2_req.last) |-> !s2_req.pend) else $error("run left after image end");
`endif

endmodule

>>> rtl/core/run_copy_image_decompressor_core.sv
// Top level of the run/copy image decompressor: config, decoder queue, pixel engine.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          action, data_byte
// result    out        empty / pop          pixel_valid, pixel, last_pixel,
//                                           run_pending, byte_rejected
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item (byte or tick) is taken per cycle while full is low; each gives exactly one
// result, and copies read one history entry per item through one registered read port.
// A result passes through the request queue, the history read stage and the pixel stage
// into the result queue. Reset clears all control state; the history store needs no
// clearing pass since a read never reaches an entry not written in the image.
// A full result queue stalls the pixel engine while the decoder fills the request queue;
// full also stays high for the cycle after a config write while the geometry settles.

module run_copy_image_decompressor_core import rcid_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic            action,
	input  logic [7:0]      data_byte,
	output logic            empty,
	input  logic            pop,
	output logic            pixel_valid,
	output logic [15:0]     pixel,
	output logic            last_pixel,
	output logic            run_pending,
	output logic            byte_rejected,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [DimW-1:0] cfg_data
);

	logic [DimW-1:0] width_q, height_q, effw, effh;
	logic            m16_q;
	logic            geom_stale_q;
	geom_t           geom_q;
	req_t            req, mid_req;
	req_t            mq_q [QDepth];
	logic [QAw-1:0]  mwp_q, mrp_q;
	logic [QAw:0]    mcnt_q;
	logic            take, mid_pop, mid_valid;
	res_t            res;

	// Configuration is always accepted: cfg_ready is tied high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(MaxWidth);
			height_q <= DimW'(MaxHeight);
			m16_q    <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_DEPTH:  m16_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the size registers and register the pixel total.
	always_comb begin
		effw = (width_q == '0) ? DimW'(1) :
			(width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
		effh = (height_q == '0) ? DimW'(1) :
			(height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= '{width: DimW'(MaxWidth), total: TotW'(MaxWidth * MaxHeight), m16: 1'b1};
		end else begin
			geom_q.width <= effw;
			geom_q.total <= TotW'({{(TotW-DimW){1'b0}}, effw} * {{(TotW-DimW){1'b0}}, effh});
			geom_q.m16   <= m16_q;
		end
	end

	// Hold off input in the cycle after a register write so the decoder sees new geometry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) geom_stale_q <= 1'b0;
		else geom_stale_q <= cfg_valid && cfg_ready;
	end

	// Accept a transfer whenever the request queue has room and no geometry update is pending.
	assign full = (mcnt_q == (QAw+1)'(QDepth)) || geom_stale_q;
	assign take = push && !full;

	rcid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.action    (action),
		.data_byte (data_byte),
		.geom      (geom_q),
		.req       (req)
	);

	// Request queue between decoder and pixel engine.
	assign mid_valid = (mcnt_q != '0);
	assign mid_req   = mq_q[mrp_q];

	always_ff @(posedge clk) begin
		if (take) mq_q[mwp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mwp_q <= '0; mrp_q <= '0; mcnt_q <= '0;
		end else begin
			if (take) mwp_q <= mwp_q + QAw'(1);
			if (mid_pop) mrp_q <= mrp_q + QAw'(1);
			mcnt_q <= mcnt_q + (QAw+1)'(take) - (QAw+1)'(mid_pop);
		end
	end

	rcid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_req   (mid_req),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign pixel_valid   = res.pv;
	assign pixel         = res.px;
	assign last_pixel    = res.last;
	assign run_pending   = res.pend;
	assign byte_rejected = res.rej;

endmodule

>>> sim/run_copy_image_decompressor_core_tb.sv
// Self-checking testbench of the run/copy image decompressor core.
`timescale 1ns / 1ps

module run_copy_image_decompressor_core_tb;
	import rcid_pkg::*;

	// Decoder phases of the local pixel predictor
	typedef enum logic [3:0] {
		PH_CMD, PH_COUNT, PH_C1LO, PH_C1HI, PH_C2LO, PH_C2HI,
		PH_LITLO, PH_LITHI, PH_PHEAD, PH_PDATA, PH_RUN
	} phase_e;

	// Kinds of entries in the pending stimulus queue
	typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_e;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam int HIST = 2 * MaxWidth;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		job_e            kind;
		logic            act;
		logic [7:0]      byt;
		logic [1:0]      idx;
		logic [DimW-1:0] val;
	} job_t;

	typedef struct {
		logic        pv;
		logic [15:0] px;
		logic        last;
		logic        pend;
		logic        rej;
	} pix_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            push = 1'b0;
	logic            full;
	logic            action = 1'b0;
	logic [7:0]      data_byte = 8'd0;
	logic            empty;
	logic            pop = 1'b0;
	logic            pixel_valid;
	logic [15:0]     pixel;
	logic            last_pixel;
	logic            run_pending;
	logic            byte_rejected;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [1:0]      cfg_index = CFG_WIDTH;
	logic [DimW-1:0] cfg_data = '0;

	run_copy_image_decompressor_core dut (.*);

	always #5 clk = ~clk;

	// Stimulus and scoreboard storage
	job_t jobs[$];
	pix_t pixels_due[$];
	int   errors = 0;
	bit   stim_done = 0;
	bit   item_taken = 0, pop_taken = 0, cfg_taken = 0;
	int   quiet_cycles = 0;
	int   stall_cycles = 0;
	int   send_gap = 0, take_gap = 0;
	bit   burst = 0;
	int   burst_left = 0;

	// Predictor state, mirrors the decoder and pixel engine
	int unsigned  p_width = 1024, p_height = 1024;
	logic         p_m16 = 1'b1;
	phase_e       p_phase = PH_CMD;
	logic [7:0]   p_cmd = '0;
	int unsigned  p_run = 0;
	logic [15:0]  p_c1 = '0, p_c2 = '0;
	logic         p_toggle = 1'b0;
	int unsigned  p_index = 0, p_hpos = 0;
	logic [15:0]  p_hist [HIST];

	function automatic int unsigned eff_width();
		if (p_width < 1) return 1;
		if (p_width > MaxWidth) return MaxWidth;
		return p_width;
	endfunction

	function automatic int unsigned eff_total();
		int unsigned h;
		h = (p_height < 1) ? 1 : (p_height > MaxHeight) ? MaxHeight : p_height;
		return eff_width() * h;
	endfunction

	// Read a pixel d places back; above the image or zero distance reads 0
	function automatic logic [15:0] hist_back(int unsigned d);
		if (d == 0 || d > p_index || d > HIST) return '0;
		return p_hist[(p_hpos + HIST - d) % HIST];
	endfunction

	// Store one pixel and close the image at its end
	function automatic void put_pixel(input logic [15:0] v, inout pix_t r);
		p_hist[p_hpos] = v;
		p_hpos = (p_hpos + 1) % HIST;
		p_index++;
		r.pv = 1'b1;
		r.px = v;
		if (p_index >= eff_total()) begin
			r.last = 1'b1;
			p_index = 0;
			p_hpos = 0;
			p_phase = PH_CMD;
			p_run = 0;
			p_toggle = 1'b0;
		end
	endfunction

	function automatic void arm_run();
		int unsigned n;
		n = p_run & 8'hFF;
		if (p_cmd == CMD_FILL) n += p_m16 ? 3 : 4;
		else if (p_cmd == CMD_PAIR) n = 2 * (n + (p_m16 ? 2 : 3));
		else n += p_m16 ? 2 : 3;
		p_run = n;
		p_toggle = 1'b0;
		p_phase = PH_RUN;
	endfunction

	function automatic void take_command(input logic [7:0] b, inout pix_t r);
		p_cmd = b;
		if (b == CMD_UP1 || b == CMD_UP2 || b == CMD_FILL || b == CMD_PAIR)
			p_phase = PH_COUNT;
		else if (b == CMD_ESC)
			p_phase = PH_LITLO;
		else if (p_m16 && b == CMD_UPLEFT)
			put_pixel(hist_back(eff_width() + 1), r);
		else if (p_m16 && b == CMD_UPRIGHT)
			put_pixel(hist_back(eff_width() - 1), r);
		else if (p_m16 && b == CMD_PACK)
			p_phase = PH_COUNT;
		else if (p_m16) begin
			p_c1 = {8'h00, b};
			p_phase = PH_LITHI;
		end else
			put_pixel({8'h00, b}, r);
	endfunction

	// Work out the result of one accepted byte or tick
	function automatic pix_t decode_step(input logic act, input logic [7:0] b);
		pix_t r;
		logic [15:0] v;
		r = '{default: '0};
		if (act == ACT_TICK) begin
			if (p_phase == PH_RUN) begin
				if (p_cmd == CMD_UP1) v = hist_back(eff_width());
				else if (p_cmd == CMD_UP2) v = hist_back(2 * eff_width());
				else if (p_cmd == CMD_PAIR) v = p_toggle ? p_c2 : p_c1;
				else v = p_c1;
				p_toggle ^= 1'b1;
				if (p_run > 0) p_run--;
				if (p_run == 0) p_phase = PH_CMD;
				put_pixel(v, r);
			end
		end else begin
			case (p_phase)
				PH_RUN: r.rej = 1'b1;
				PH_COUNT: begin
					p_run = b;
					if (p_cmd == CMD_FILL || p_cmd == CMD_PAIR) p_phase = PH_C1LO;
					else if (p_cmd == CMD_PACK) p_phase = PH_PHEAD;
					else arm_run();
				end
				PH_C1LO: begin
					p_c1 = {8'h00, b};
					if (p_m16) p_phase = PH_C1HI;
					else if (p_cmd == CMD_PAIR) p_phase = PH_C2LO;
					else arm_run();
				end
				PH_C1HI: begin
					p_c1[15:8] = b;
					if (p_cmd == CMD_PAIR) p_phase = PH_C2LO;
					else arm_run();
				end
				PH_C2LO: begin
					p_c2 = {8'h00, b};
					if (p_m16) p_phase = PH_C2HI;
					else arm_run();
				end
				PH_C2HI: begin
					p_c2[15:8] = b;
					arm_run();
				end
				PH_LITLO: begin
					p_c1 = {8'h00, b};
					if (p_m16) p_phase = PH_LITHI;
					else begin
						p_phase = PH_CMD;
						put_pixel({8'h00, b}, r);
					end
				end
				PH_LITHI: begin
					p_phase = PH_CMD;
					put_pixel({b, p_c1[7:0]}, r);
				end
				PH_PHEAD: begin
					p_c1 = {b[7:5], 2'b00, b[4:3], 4'b0000, b[2:0], 2'b00};
					p_run = (p_run & 8'hFF) + 1;
					p_phase = PH_PDATA;
				end
				PH_PDATA: begin
					v = p_c1 | {3'b000, b[7:6], 2'b00, b[5:2], 5'b00000} | {14'd0, b[1:0]};
					if (p_run > 0) p_run--;
					if (p_run == 0) p_phase = PH_CMD;
					put_pixel(v, r);
				end
				default: begin
					p_phase = PH_CMD;
					take_command(b, r);
				end
			endcase
		end
		r.pend = (p_phase == PH_RUN);
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
	endtask

	// Stimulus queue builders
	int item_count = 0;
	logic gen_m16 = 1'b1;

	task automatic add_byte(input logic [7:0] b);
		jobs.push_back('{JOB_ITEM, ACT_BYTE, b, CFG_WIDTH, '0});
		item_count++;
	endtask

	task automatic add_ticks(input int n);
		repeat (n) begin
			jobs.push_back('{JOB_ITEM, ACT_TICK, 8'($urandom), CFG_WIDTH, '0});
			item_count++;
		end
	endtask

	task automatic add_cfg(input logic [1:0] i, input int unsigned v);
		jobs.push_back('{JOB_CFG, ACT_BYTE, 8'd0, i, DimW'(v)});
		if (i == CFG_DEPTH) gen_m16 = v[0];
	endtask

	task automatic add_setting(input int unsigned w, input int unsigned h, input logic m);
		add_cfg(CFG_WIDTH, w);
		add_cfg(CFG_HEIGHT, h);
		add_cfg(CFG_DEPTH, m);
	endtask

	task automatic add_drain();
		jobs.push_back('{JOB_DRAIN, ACT_BYTE, 8'd0, CFG_WIDTH, '0});
	endtask

	task automatic add_color();
		add_byte(8'($urandom));
		if (gen_m16) add_byte(8'($urandom));
	endtask

	// One well-formed command with random content, with some noise mixed in
	task automatic add_command();
		int sel, n, len;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
		sel = $urandom_range(0, 11);
		case (sel)
			0, 1: begin
				add_byte(sel == 0 ? CMD_UP1 : CMD_UP2);
				add_byte(8'(n));
				len = n + (gen_m16 ? 2 : 3);
			end
			2: begin
				add_byte(CMD_FILL);
				add_byte(8'(n));
				add_color();
				len = n + (gen_m16 ? 3 : 4);
			end
			3: begin
				if (n > 60) n = n / 8;
				add_byte(CMD_PAIR);
				add_byte(8'(n));
				add_color();
				add_color();
				len = 2 * (n + (gen_m16 ? 2 : 3));
			end
			4: begin
				add_byte(CMD_ESC);
				add_color();
				len = 0;
			end
			5: begin
				add_byte(CMD_UPLEFT);
				len = 0;
			end
			6: begin
				add_byte(CMD_UPRIGHT);
				len = 0;
			end
			7: begin
				add_byte(CMD_PACK);
				add_byte(8'(n));
				repeat (n + 2) add_byte(8'($urandom));
				len = 0;
			end
			default: begin
				add_byte(8'($urandom_range(0, CMD_ESC - 1)));
				if (gen_m16) add_byte(8'($urandom));
				len = 0;
			end
		endcase
		// Mostly exact tick counts; sometimes short or long, sometimes a stray byte
		if (len > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				add_ticks($urandom_range(0, len));
				add_byte(8'($urandom));
				add_ticks(len);
			end else
				add_ticks(len + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0));
		end else if ($urandom_range(0, 15) == 0)
			add_ticks(1);
	endtask

	// Build the whole run: directed cases, then random phases at various settings
	initial begin : build_jobs
		int phase, goal;
		int unsigned w, h;
		// 8-bit, 4x3 image: literals, escape, fill, copies, pair, rejection, idle tick
		add_setting(4, 3, 1'b0);
		add_ticks(1);
		add_byte(8'h00);
		add_byte(CMD_ESC); add_byte(8'hFF);
		add_byte(8'hF7);
		add_byte(CMD_UPLEFT);
		add_byte(CMD_UP1); add_byte(8'h00); add_ticks(1);
		add_byte(8'h5A); add_ticks(2);
		add_byte(CMD_UP2); add_byte(8'h00); add_ticks(3);
		add_byte(CMD_FILL); add_byte(8'h01); add_byte(8'hAA); add_ticks(5);
		add_byte(CMD_PAIR); add_byte(8'h00); add_byte(8'h11); add_byte(8'h22); add_ticks(6);
		add_drain();
		// 16-bit, width 1: up-left, zero-distance up-right, packed, literal
		add_setting(1, 6, 1'b1);
		add_byte(CMD_UPRIGHT);
		add_byte(CMD_UPLEFT);
		add_byte(CMD_PACK); add_byte(8'h00); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h00);
		add_byte(8'h34); add_byte(8'h12);
		add_byte(CMD_FILL); add_byte(8'h03); add_byte(8'hCD); add_byte(8'hAB); add_ticks(2);
		add_drain();
		phase = 0;
		while (item_count < 1650) begin
			case (phase % 8)
				0: add_setting(1, 1, 1'b0);
				1: add_setting(1024, 1024, 1'b1);
				2: add_setting(1, 40, 1'b1);
				3: add_setting(1024, 1, 1'b0);
				4: add_setting(5, 4, 1'b1);
				default: begin
					w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 12);
					h = $urandom_range(1, 8);
					add_setting(w, h, 1'($urandom));
				end
			endcase
			goal = item_count + 180;
			while (item_count < goal) begin
				add_command();
				if ($urandom_range(0, 59) == 0) add_drain();
				// Change depth mid-phase now and then, at an idle point
				if ($urandom_range(0, 99) == 0) begin
					add_drain();
					add_cfg(CFG_DEPTH, !gen_m16);
				end
			end
			add_drain();
			phase++;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
	end

	// Monitor: predict on accepted items, check accepted results, track idleness
	always @(posedge clk) begin
		pix_t want;
		item_taken = push && !full;
		pop_taken = pop && !empty;
		cfg_taken = cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_taken) begin
				case (cfg_index)
					CFG_WIDTH:  p_width = cfg_data;
					CFG_HEIGHT: p_height = cfg_data;
					CFG_DEPTH:  p_m16 = cfg_data[0];
					default: ;
				endcase
			end
			if (item_taken)
				pixels_due.push_back(decode_step(action, data_byte));
			if (pop_taken) begin
				if (pixels_due.size() == 0) begin
					report("unexpected result transfer", pixel, 0);
				end else begin
					want = pixels_due.pop_front();
					if (pixel_valid !== want.pv) report("pixel_valid", pixel_valid, want.pv);
					if (pixel !== want.px) report("pixel", pixel, want.px);
					if (last_pixel !== want.last) report("last_pixel", last_pixel, want.last);
					if (run_pending !== want.pend) report("run_pending", run_pending, want.pend);
					if (byte_rejected !== want.rej)
						report("byte_rejected", byte_rejected, want.rej);
				end
			end
			quiet_cycles = (pixels_due.size() == 0 && !push) ? quiet_cycles + 1 : 0;
			// Watchdog: no transfer of any kind for too long
			stall_cycles = (item_taken || pop_taken || cfg_taken) ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("run_copy_image_decompressor_core_tb NOT OK");
				$finish;
			end
		end
	end

	// Driver: feed items and register writes from the job queue at the falling edge
	always @(negedge clk) begin
		logic nxt_push, nxt_cfg, nxt_pop;
		job_t j;
		nxt_push = push;
		nxt_cfg = cfg_valid;
		nxt_pop = pop;
		if (arst_n) begin
			// Switch between stretches with random gaps and full-rate stretches
			if (burst_left == 0) begin
				burst = ($urandom_range(0, 3) == 0);
				burst_left = $urandom_range(20, 120);
			end else
				burst_left--;
			if (push && item_taken) begin
				nxt_push = 1'b0;
				send_gap = burst ? 0 : $urandom_range(0, 17);
			end
			if (cfg_valid && cfg_taken) nxt_cfg = 1'b0;
			if (!nxt_push && !nxt_cfg) begin
				if (send_gap > 0)
					send_gap--;
				else if (jobs.size() > 0) begin
					j = jobs[0];
					case (j.kind)
						JOB_ITEM: begin
							nxt_push = 1'b1;
							action <= j.act;
							data_byte <= j.byt;
							void'(jobs.pop_front());
						end
						JOB_CFG: if (quiet_cycles >= SETTLE_CYCLES) begin
							nxt_cfg = 1'b1;
							cfg_index <= j.idx;
							cfg_data <= j.val;
							void'(jobs.pop_front());
						end
						default: if (quiet_cycles >= SETTLE_CYCLES) void'(jobs.pop_front());
					endcase
				end else
					stim_done = 1;
			end
			// Result side: hold pop off for a random count after each transfer
			if (pop_taken) begin
				take_gap = burst ? 0 : $urandom_range(0, 17);
				nxt_pop = (take_gap == 0);
			end else if (!pop) begin
				if (take_gap > 0) take_gap--;
				nxt_pop = (take_gap == 0);
			end
		end
		push <= nxt_push;
		cfg_valid <= nxt_cfg;
		pop <= nxt_pop;
	end

	// End of run: drain, let the pipeline settle, then give the verdict
	initial begin
		wait (stim_done);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("run_copy_image_decompressor_core_tb OK");
		else
			$display("run_copy_image_decompressor_core_tb NOT OK");
		$finish;
	end

endmodule
